// ===== rtl/ghsc_pkg.sv =====
package ghsc_pkg;

    // Operand selection for the shared cross-product unit
    typedef enum logic [1:0] {
        GEO_SORT = 2'd0,   // key - pivot against store entry - pivot
        GEO_SCAN = 2'd1,   // top - second against point - top
        GEO_C1   = 2'd2,   // turn at hull vertex i
        GEO_C2   = 2'd3    // turn at hull vertex i+1
    } geo_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     load;
        logic     sort_init;
        logic     set_j;
        logic     rd_store_jm1;
        logic     key_ld;
        logic     a_ld;
        logic     wr_j_a;
        logic     wr_j_key;
        logic     j_dec;
        logic     i_inc;
        logic     geo_go;
        geo_sel_t geo_sel;
        logic     hull_init;
        logic     pop;
        logic     s_ld;
        logic     push;
        logic     chk_top;
        logic     chk_base;
        logic     w2_ld;
        logic     w3_ld;
        logic     c1_ld;
        logic     fail;
        logic     shift;
        logic     emit;
    } ghsc_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic i_ge_n;
        logic j_le1;
        logic cnt_gt1;
        logic i_next_ge_cnt;
        logic key_first;
        logic cross_neg;
        logic cross_zero;
        logic c1;
        logic out_busy;
    } ghsc_status_t;

endpackage

// ===== rtl/ghsc_point_if.sv =====
interface ghsc_point_if #(
    parameter int COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] y_coord;
    logic                  last_point;

    modport source (output valid, x_coord, y_coord, last_point, input ready);
    modport sink   (input valid, x_coord, y_coord, last_point, output ready);
endinterface

// ===== rtl/ghsc_result_if.sv =====
interface ghsc_result_if;
    logic valid;
    logic ready;
    logic is_stable;

    modport source (output valid, is_stable, input ready);
    modport sink   (input valid, is_stable, output ready);
endinterface

// ===== rtl/graham_hull_stability_check_top.sv =====
// Convex hull stability check.
// Input channel pts: one point per item (x_coord, y_coord, last_point).
// Points load at one item per cycle; the item with last_point set closes
// the set and starts the run. Points beyond MAX_POINTS are dropped.
// Output channel res: one item per set, is_stable = 1 for Yes, 0 for No.
// Run after the closing item:
//   angular insertion sort, each compare waiting on the 3-stage
//   cross-product unit;
//   Graham scan;
//   closing check over each hull vertex, stopping at the first failure.
// The answer is then sent through the result register.
// pts is not ready while a set is being processed. The result is held in
// an output register, so loading of the next set goes on while res is
// stalled; only the end of the next run waits for it to be taken.
// Reset (rst_n, asynchronous, active low) empties the set and clears the
// result valid flag; point and hull memories keep whatever they held.
module graham_hull_stability_check_top #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input logic           clk,
    input logic           rst_n,
    ghsc_point_if.sink    pts,
    ghsc_result_if.source res
);
    ghsc_pkg::ghsc_cmd_t    cmd;
    ghsc_pkg::ghsc_status_t status;

    // sequencer: sort, scan and check phases
    ghsc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // memories, counters and the shared cross-product unit
    ghsc_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .pts    (pts),
        .res    (res),
        .cmd    (cmd),
        .status (status)
    );
endmodule

// ===== rtl/ghsc_ram.sv =====
module ghsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/ghsc_datapath.sv =====
module ghsc_datapath #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    ghsc_point_if.sink             pts,
    ghsc_result_if.source          res,
    input  ghsc_pkg::ghsc_cmd_t    cmd,
    output ghsc_pkg::ghsc_status_t status
);
    localparam int CB = COORD_BITS;
    localparam int PW = 2 * CB;
    localparam int D  = CB + 1;
    localparam int PR = 2 * D;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int HD = MAX_POINTS + 2;
    localparam int HW = $clog2(HD);

    function automatic logic signed [D-1:0] diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        diff = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    endfunction

    logic [NW-1:0] n_reg, i_reg, j_reg, cnt_reg;
    logic [PW-1:0] piv_reg, key_reg, a_reg, t_reg, s_reg;
    logic [PW-1:0] w0_reg, w1_reg, w2_reg, w3_reg;
    logic          ok_reg, c1_reg, out_valid_reg, out_data_reg;

    logic [PW-1:0] pt, store_rdata, hull_rdata, store_wdata, hull_wdata;
    logic [AW-1:0] store_waddr, store_raddr;
    logic [HW-1:0] hull_waddr, hull_raddr;
    logic          store_we, hull_we, fire, beats_pivot;
    logic [NW:0]   cnt_ext, i_ext, hull_ra_wide, hull_wa_wide;

    assign pt          = {pts.x_coord, pts.y_coord};
    assign fire        = pts.valid && cmd.in_ready;
    assign pts.ready   = cmd.in_ready;
    assign cnt_ext     = {1'b0, cnt_reg};
    assign i_ext       = {1'b0, i_reg};
    assign beats_pivot = ($signed(pt[CB-1:0]) < $signed(piv_reg[CB-1:0]))
                      || ((pt[CB-1:0] == piv_reg[CB-1:0])
                          && ($signed(pt[PW-1:CB]) < $signed(piv_reg[PW-1:CB])));

    // point store
    always_comb
    begin
        store_we    = 1'b0;
        store_waddr = j_reg[AW-1:0];
        store_wdata = key_reg;
        if (cmd.load && fire && (n_reg < NW'(MAX_POINTS)) && (n_reg != '0))
        begin
            store_we    = 1'b1;
            store_waddr = n_reg[AW-1:0];
            store_wdata = beats_pivot ? piv_reg : pt;
        end
        else if (cmd.wr_j_a)
        begin
            store_we    = 1'b1;
            store_wdata = a_reg;
        end
        else if (cmd.wr_j_key)
        begin
            store_we    = 1'b1;
        end
        store_raddr = cmd.rd_store_jm1 ? AW'(j_reg - NW'(1)) : i_reg[AW-1:0];
    end

    ghsc_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // hull stack
    always_comb
    begin
        hull_we      = 1'b0;
        hull_wa_wide = cnt_ext + (NW+1)'(1);
        hull_wdata   = piv_reg;
        priority if (cmd.hull_init)
        begin
            hull_we      = 1'b1;
            hull_wa_wide = (NW+1)'(1);
        end
        else if (cmd.push)
        begin
            hull_we    = 1'b1;
            hull_wdata = key_reg;
        end
        else if (cmd.chk_top)
        begin
            hull_we = 1'b1;
        end
        else if (cmd.chk_base)
        begin
            hull_we      = 1'b1;
            hull_wa_wide = '0;
            hull_wdata   = t_reg;
        end
        else
        begin
            hull_we = 1'b0;
        end

        priority if (cmd.pop)
            hull_ra_wide = cnt_ext - (NW+1)'(2);
        else if (cmd.chk_base)
            hull_ra_wide = (NW+1)'(2);
        else if (cmd.w2_ld)
            hull_ra_wide = (NW+1)'(3);
        else
            hull_ra_wide = i_ext + (NW+1)'(3);
        hull_waddr = hull_wa_wide[HW-1:0];
        hull_raddr = hull_ra_wide[HW-1:0];
    end

    ghsc_ram #(.WIDTH(PW), .DEPTH(HD)) u_hull (
        .clk   (clk),
        .we    (hull_we),
        .waddr (hull_waddr),
        .wdata (hull_wdata),
        .raddr (hull_raddr),
        .rdata (hull_rdata)
    );

    // control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            ok_reg        <= 1'b1;
            c1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            piv_reg       <= '0;
        end
        else
        begin
            if (cmd.load && fire && (n_reg < NW'(MAX_POINTS)))
            begin
                n_reg <= n_reg + NW'(1);
                if ((n_reg == '0) || beats_pivot)
                begin
                    piv_reg <= pt;
                end
            end
            if (cmd.emit)
            begin
                n_reg <= '0;
            end
            if (cmd.sort_init)
                i_reg <= NW'(2);
            else if (cmd.hull_init || cmd.chk_base)
                i_reg <= NW'(1);
            else if (cmd.i_inc)
                i_reg <= i_reg + NW'(1);
            if (cmd.set_j)
                j_reg <= i_reg;
            else if (cmd.j_dec)
                j_reg <= j_reg - NW'(1);
            if (cmd.hull_init)
                cnt_reg <= NW'(1);
            else if (cmd.push)
                cnt_reg <= cnt_reg + NW'(1);
            else if (cmd.pop)
                cnt_reg <= cnt_reg - NW'(1);
            if (cmd.chk_base)
                ok_reg <= 1'b1;
            else if (cmd.fail)
                ok_reg <= 1'b0;
            if (cmd.c1_ld)
                c1_reg <= status.cross_zero;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // point registers
    always_ff @(posedge clk)
    begin
        if (cmd.key_ld)
            key_reg <= store_rdata;
        if (cmd.a_ld)
            a_reg <= store_rdata;
        if (cmd.hull_init)
            t_reg <= piv_reg;
        else if (cmd.push)
        begin
            t_reg <= key_reg;
            s_reg <= t_reg;
        end
        else if (cmd.pop)
            t_reg <= s_reg;
        if (cmd.s_ld)
            s_reg <= hull_rdata;
        if (cmd.chk_base)
        begin
            w0_reg <= t_reg;
            w1_reg <= piv_reg;
        end
        else if (cmd.shift)
        begin
            w0_reg <= w1_reg;
            w1_reg <= w2_reg;
        end
        if (cmd.w2_ld)
            w2_reg <= hull_rdata;
        else if (cmd.shift)
            w2_reg <= w3_reg;
        if (cmd.w3_ld)
            w3_reg <= hull_rdata;
        if (cmd.emit)
            out_data_reg <= ok_reg;
    end

    // cross-product unit: differences, products, then sums and compares
    logic [PW-1:0]         a1, a0, b1, b0;
    logic signed [D-1:0]   ux_n, uy_n, vx_n, vy_n;
    logic signed [D-1:0]   ux_reg, uy_reg, vx_reg, vy_reg;
    logic                  uz1_reg, vz1_reg, uz2_reg, vz2_reg, uz3_reg, vz3_reg;
    logic signed [PR-1:0]  p1_reg, p2_reg;
    logic signed [PR-1:0]  uxx_s, uyy_s, vxx_s, vyy_s;
    logic [PR-1:0]         uxx_reg, uyy_reg, vxx_reg, vyy_reg;
    logic signed [PR:0]    cross_reg;
    logic                  lt_reg;

    always_comb
    begin
        unique case (cmd.geo_sel)
            ghsc_pkg::GEO_SORT:
            begin
                a1 = key_reg; a0 = piv_reg; b1 = a_reg; b0 = piv_reg;
            end
            ghsc_pkg::GEO_SCAN:
            begin
                a1 = t_reg; a0 = s_reg; b1 = key_reg; b0 = t_reg;
            end
            ghsc_pkg::GEO_C1:
            begin
                a1 = w1_reg; a0 = w0_reg; b1 = w2_reg; b0 = w1_reg;
            end
            default:
            begin
                a1 = w2_reg; a0 = w1_reg; b1 = w3_reg; b0 = w2_reg;
            end
        endcase
        ux_n = diff(a1[PW-1:CB], a0[PW-1:CB]);
        uy_n = diff(a1[CB-1:0], a0[CB-1:0]);
        vx_n = diff(b1[PW-1:CB], b0[PW-1:CB]);
        vy_n = diff(b1[CB-1:0], b0[CB-1:0]);
    end

    assign uxx_s = ux_reg * ux_reg;
    assign uyy_s = uy_reg * uy_reg;
    assign vxx_s = vx_reg * vx_reg;
    assign vyy_s = vy_reg * vy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.geo_go)
        begin
            ux_reg  <= ux_n;
            uy_reg  <= uy_n;
            vx_reg  <= vx_n;
            vy_reg  <= vy_n;
            uz1_reg <= (ux_n == '0) && (uy_n == '0);
            vz1_reg <= (vx_n == '0) && (vy_n == '0);
        end
        p1_reg    <= ux_reg * vy_reg;
        p2_reg    <= uy_reg * vx_reg;
        uxx_reg   <= uxx_s;
        uyy_reg   <= uyy_s;
        vxx_reg   <= vxx_s;
        vyy_reg   <= vyy_s;
        uz2_reg   <= uz1_reg;
        vz2_reg   <= vz1_reg;
        cross_reg <= $signed({p1_reg[PR-1], p1_reg}) - $signed({p2_reg[PR-1], p2_reg});
        lt_reg    <= ({1'b0, uxx_reg} + {1'b0, uyy_reg}) < ({1'b0, vxx_reg} + {1'b0, vyy_reg});
        uz3_reg   <= uz2_reg;
        vz3_reg   <= vz2_reg;
    end

    always_comb
    begin
        status.in_valid      = pts.valid;
        status.in_last       = pts.last_point;
        status.i_ge_n        = i_reg >= n_reg;
        status.j_le1         = j_reg <= NW'(1);
        status.cnt_gt1       = cnt_reg > NW'(1);
        status.i_next_ge_cnt = (i_ext + (NW+1)'(1)) >= cnt_ext;
        status.cross_neg     = cross_reg < 0;
        status.cross_zero    = cross_reg == '0;
        status.c1            = c1_reg;
        status.out_busy      = out_valid_reg && !res.ready;
        priority if (vz3_reg)
            status.key_first = 1'b0;
        else if (uz3_reg)
            status.key_first = 1'b1;
        else if (cross_reg != '0)
            status.key_first = cross_reg > 0;
        else
            status.key_first = lt_reg;
    end

    assign res.valid     = out_valid_reg;
    assign res.is_stable = out_data_reg;
endmodule

// ===== rtl/ghsc_ctrl.sv =====
module ghsc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ghsc_pkg::ghsc_status_t status,
    output ghsc_pkg::ghsc_cmd_t    cmd
);
    typedef enum logic [25:0] {
        ST_IDLE     = 26'd1 << 0,
        ST_S_OUTER  = 26'd1 << 1,
        ST_S_KEY    = 26'd1 << 2,
        ST_S_INNER  = 26'd1 << 3,
        ST_S_RD     = 26'd1 << 4,
        ST_S_GO     = 26'd1 << 5,
        ST_GW1      = 26'd1 << 6,
        ST_GW2      = 26'd1 << 7,
        ST_S_DEC    = 26'd1 << 8,
        ST_S_PLACE  = 26'd1 << 9,
        ST_H_INIT   = 26'd1 << 10,
        ST_H_OUTER  = 26'd1 << 11,
        ST_H_KEY    = 26'd1 << 12,
        ST_H_TEST   = 26'd1 << 13,
        ST_H_DEC    = 26'd1 << 14,
        ST_H_POP    = 26'd1 << 15,
        ST_H_PUSH   = 26'd1 << 16,
        ST_C_TOP    = 26'd1 << 17,
        ST_C_BASE   = 26'd1 << 18,
        ST_C_R2     = 26'd1 << 19,
        ST_C_R3     = 26'd1 << 20,
        ST_C_G1     = 26'd1 << 21,
        ST_C_D1     = 26'd1 << 22,
        ST_C_D2     = 26'd1 << 23,
        ST_C_SH     = 26'd1 << 24,
        ST_DONE     = 26'd1 << 25
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.geo_sel = ghsc_pkg::GEO_SORT;
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load     = 1'b1;
                if (status.in_valid && status.in_last)
                begin
                    cmd.sort_init = 1'b1;
                    state_next    = ST_S_OUTER;
                end
            end
            ST_S_OUTER:
            begin
                cmd.set_j = 1'b1;
                state_next = status.i_ge_n ? ST_H_INIT : ST_S_KEY;
            end
            ST_S_KEY:
            begin
                cmd.key_ld = 1'b1;
                state_next = ST_S_INNER;
            end
            ST_S_INNER:
            begin
                cmd.rd_store_jm1 = 1'b1;
                state_next = status.j_le1 ? ST_S_PLACE : ST_S_RD;
            end
            ST_S_RD:
            begin
                cmd.a_ld = 1'b1;
                state_next = ST_S_GO;
            end
            ST_S_GO:
            begin
                cmd.geo_go  = 1'b1;
                cmd.geo_sel = ghsc_pkg::GEO_SORT;
                ret_next    = ST_S_DEC;
                state_next  = ST_GW1;
            end
            ST_GW1:
            begin
                state_next = ST_GW2;
            end
            ST_GW2:
            begin
                state_next = ret_reg;
            end
            ST_S_DEC:
            begin
                if (status.key_first)
                begin
                    cmd.wr_j_a = 1'b1;
                    cmd.j_dec  = 1'b1;
                    state_next = ST_S_INNER;
                end
                else
                begin
                    state_next = ST_S_PLACE;
                end
            end
            ST_S_PLACE:
            begin
                cmd.wr_j_key = 1'b1;
                cmd.i_inc    = 1'b1;
                state_next   = ST_S_OUTER;
            end
            ST_H_INIT:
            begin
                cmd.hull_init = 1'b1;
                state_next    = ST_H_OUTER;
            end
            ST_H_OUTER:
            begin
                state_next = status.i_ge_n ? ST_C_TOP : ST_H_KEY;
            end
            ST_H_KEY:
            begin
                cmd.key_ld = 1'b1;
                state_next = ST_H_TEST;
            end
            ST_H_TEST:
            begin
                if (status.cnt_gt1)
                begin
                    cmd.geo_go  = 1'b1;
                    cmd.geo_sel = ghsc_pkg::GEO_SCAN;
                    ret_next    = ST_H_DEC;
                    state_next  = ST_GW1;
                end
                else
                begin
                    state_next = ST_H_PUSH;
                end
            end
            ST_H_DEC:
            begin
                if (status.cross_neg)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_H_POP;
                end
                else
                begin
                    state_next = ST_H_PUSH;
                end
            end
            ST_H_POP:
            begin
                cmd.s_ld   = 1'b1;
                state_next = ST_H_TEST;
            end
            ST_H_PUSH:
            begin
                cmd.push   = 1'b1;
                cmd.i_inc  = 1'b1;
                state_next = ST_H_OUTER;
            end
            ST_C_TOP:
            begin
                cmd.chk_top = 1'b1;
                state_next  = ST_C_BASE;
            end
            ST_C_BASE:
            begin
                cmd.chk_base = 1'b1;
                state_next   = status.cnt_gt1 ? ST_C_R2 : ST_DONE;
            end
            ST_C_R2:
            begin
                cmd.w2_ld  = 1'b1;
                state_next = ST_C_R3;
            end
            ST_C_R3:
            begin
                cmd.w3_ld  = 1'b1;
                state_next = ST_C_G1;
            end
            ST_C_G1:
            begin
                cmd.geo_go  = 1'b1;
                cmd.geo_sel = ghsc_pkg::GEO_C1;
                ret_next    = ST_C_D1;
                state_next  = ST_GW1;
            end
            ST_C_D1:
            begin
                cmd.c1_ld   = 1'b1;
                cmd.geo_go  = 1'b1;
                cmd.geo_sel = ghsc_pkg::GEO_C2;
                ret_next    = ST_C_D2;
                state_next  = ST_GW1;
            end
            ST_C_D2:
            begin
                if (!status.c1 && !status.cross_zero)
                begin
                    cmd.fail   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.i_inc = 1'b1;
                    if (status.i_next_ge_cnt)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.shift  = 1'b1;
                        state_next = ST_C_SH;
                    end
                end
            end
            ST_C_SH:
            begin
                cmd.w3_ld  = 1'b1;
                state_next = ST_C_G1;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
